### hdl/ppp_pkg.sv
// Shared types and constants for the perspective point projection block.
package ppp_pkg;

    // Number of quotient bits, one division cell per bit
    localparam int QBITS = 32;
    // Width of the dot products and of the divisor and remainder
    localparam int DW = 64;
    // Configuration address width (8-byte register pitch)
    localparam int AW = 6;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_ROW0_AB  = 3'd0,
        REG_H02_H10  = 3'd1,
        REG_H11_H12  = 3'd2,
        REG_H20_H21  = 3'd3,
        REG_H22      = 3'd4,
        REG_COLS     = 3'd5,
        REG_ROWS     = 3'd6,
        REG_NONE     = 3'd7
    } t_reg_idx;

    // Colour carried alongside a point
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_color;

    // Per-lane division state handed from cell to cell
    typedef struct packed {
        logic [DW-1:0]    rem;
        logic [QBITS-1:0] low;
        logic [QBITS-1:0] quo;
    } t_lane;

    // Word side data travelling with the division
    typedef struct packed {
        logic [DW-1:0] dmag;
        logic          negx;
        logic          negy;
        logic          ovfx;
        logic          ovfy;
        logic          nxneg;
        logic          nyneg;
        logic          degen;
        t_color        color;
    } t_side;

endpackage

### hdl/ppp_dot.sv
// Two-stage dot product unit: six products, then three sums in Q.34.
module ppp_dot
    import ppp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_ready_dn,
    input  logic signed [31:0]   i_x,
    input  logic signed [31:0]   i_y,
    input  t_color               i_color,
    input  logic signed [31:0]   i_h00,
    input  logic signed [31:0]   i_h01,
    input  logic signed [31:0]   i_h02,
    input  logic signed [31:0]   i_h10,
    input  logic signed [31:0]   i_h11,
    input  logic signed [31:0]   i_h12,
    input  logic signed [31:0]   i_h20,
    input  logic signed [31:0]   i_h21,
    input  logic signed [31:0]   i_h22,
    output logic                 o_valid,
    output logic signed [DW-1:0] o_nx,
    output logic signed [DW-1:0] o_ny,
    output logic signed [DW-1:0] o_dn,
    output t_color               o_color
);

    logic signed [63:0] r_p [0:5];
    t_color             r_color1;
    logic               r_v1;
    logic               r_v2;
    logic               rdy1;
    logic               rdy2;
    logic signed [DW-1:0] n_nx;
    logic signed [DW-1:0] n_ny;
    logic signed [DW-1:0] n_dn;

    assign rdy2    = !r_v2 || i_ready_dn;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v2;

    // Stage one: exact products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_p[0]   <= i_x * i_h00;
            r_p[1]   <= i_y * i_h01;
            r_p[2]   <= i_x * i_h10;
            r_p[3]   <= i_y * i_h11;
            r_p[4]   <= i_x * i_h20;
            r_p[5]   <= i_y * i_h21;
            r_color1 <= i_color;
        end
    end

    // Stage two: floor each product by four, add the widened constant
    always_comb begin
        n_nx = (r_p[0] >>> 2) + (r_p[1] >>> 2) + $signed({{18{i_h02[31]}}, i_h02, 14'd0});
        n_ny = (r_p[2] >>> 2) + (r_p[3] >>> 2) + $signed({{18{i_h12[31]}}, i_h12, 14'd0});
        n_dn = (r_p[4] >>> 2) + (r_p[5] >>> 2) + $signed({{18{i_h22[31]}}, i_h22, 14'd0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            o_nx    <= n_nx;
            o_ny    <= n_ny;
            o_dn    <= n_dn;
            o_color <= r_color1;
        end
    end

endmodule

### hdl/ppp_div_cell.sv
// One restoring division cell: resolves one quotient bit for both lanes.
module ppp_div_cell
    import ppp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  logic   i_ready_dn,
    input  t_lane  i_lane_x,
    input  t_lane  i_lane_y,
    input  t_side  i_side,
    output logic   o_valid,
    output t_lane  o_lane_x,
    output t_lane  o_lane_y,
    output t_side  o_side
);

    logic  r_valid;
    t_lane n_lane_x;
    t_lane n_lane_y;

    assign o_ready = !r_valid || i_ready_dn;
    assign o_valid = r_valid;

    // Shift in the next dividend bit, subtract the divisor where it fits
    function automatic t_lane step(input t_lane l, input logic [DW-1:0] d);
        logic [DW:0] rem2;
        logic        ge;
        t_lane       r;
        rem2  = {l.rem, l.low[QBITS-1]};
        ge    = rem2 >= {1'b0, d};
        r.rem = ge ? DW'(rem2 - {1'b0, d}) : rem2[DW-1:0];
        r.low = {l.low[QBITS-2:0], 1'b0};
        r.quo = {l.quo[QBITS-2:0], ge};
        return r;
    endfunction

    assign n_lane_x = step(i_lane_x, i_side.dmag);
    assign n_lane_y = step(i_lane_y, i_side.dmag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            o_lane_x <= n_lane_x;
            o_lane_y <= n_lane_y;
            o_side   <= i_side;
        end
    end

endmodule

### hdl/perspective_point_projection.sv
// Top level of the perspective point projection block.
//
// Input channel: i_valid / o_stall with the point (Q16.16) and its colour.
// Output channel: o_valid / i_stall with the projected point, pixel column
// and row, inside and degenerate flags and the colour.
// A word is taken at every edge where valid is high and stall is low.
// Throughput: one word per cycle while no stall holds the flow. A word
// passes the product registers at the accepting edge, then the sums register,
// the setup register, a chain of 32 division cells (one quotient bit each, both
// coordinates in parallel) and one output stage.
// Each stage holds its word only while the stage after it is full and held,
// so empty slots close up and input keeps flowing while a result waits.
// When the receiver stalls, the output word holds and the chain fills behind
// it; o_stall rises once no slot is free.
// Synchronous reset empties every stage and loads the identity matrix,
// h22 = 1.0 and a 640 x 480 image.
// Registers are written through the APB port at byte address 8*index; the user
// writes them only while no word is in flight (the block does not enforce this).
module perspective_point_projection
    import ppp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AW-1:0]        paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [31:0]   i_point_x,
    input  logic signed [31:0]   i_point_y,
    input  logic [7:0]           i_red_in,
    input  logic [7:0]           i_green_in,
    input  logic [7:0]           i_blue_in,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [31:0]   o_proj_x,
    output logic signed [31:0]   o_proj_y,
    output logic signed [15:0]   o_pixel_col,
    output logic signed [15:0]   o_pixel_row,
    output logic                 o_inside_res,
    output logic                 o_degenerate,
    output logic [7:0]           o_red_out,
    output logic [7:0]           o_green_out,
    output logic [7:0]           o_blue_out
);

    // Configuration registers
    logic [63:0] r_row0_ab;
    logic [63:0] r_h02_h10;
    logic [63:0] r_h11_h12;
    logic [63:0] r_h20_h21;
    logic [31:0] r_h22;
    logic [12:0] r_cols;
    logic [12:0] r_rows;
    t_reg_idx    reg_idx;

    assign reg_idx = t_reg_idx'(paddr[AW-1:3]);
    assign pready  = 1'b1;

    // Write registers on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row0_ab <= 64'h0010_0000_0000_0000;
            r_h02_h10 <= 64'd0;
            r_h11_h12 <= 64'h0010_0000_0000_0000;
            r_h20_h21 <= 64'd0;
            r_h22     <= 32'h0010_0000;
            r_cols    <= 13'd640;
            r_rows    <= 13'd480;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_ROW0_AB: r_row0_ab <= pwdata;
                REG_H02_H10: r_h02_h10 <= pwdata;
                REG_H11_H12: r_h11_h12 <= pwdata;
                REG_H20_H21: r_h20_h21 <= pwdata;
                REG_H22:     r_h22     <= pwdata[31:0];
                REG_COLS:    r_cols    <= pwdata[12:0];
                REG_ROWS:    r_rows    <= pwdata[12:0];
                default:     ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            REG_ROW0_AB: prdata = r_row0_ab;
            REG_H02_H10: prdata = r_h02_h10;
            REG_H11_H12: prdata = r_h11_h12;
            REG_H20_H21: prdata = r_h20_h21;
            REG_H22:     prdata = {32'd0, r_h22};
            REG_COLS:    prdata = {51'd0, r_cols};
            REG_ROWS:    prdata = {51'd0, r_rows};
            default:     prdata = 64'd0;
        endcase
    end

    // Dot products
    logic                 dot_ready;
    logic                 dot_valid;
    logic signed [DW-1:0] dot_nx;
    logic signed [DW-1:0] dot_ny;
    logic signed [DW-1:0] dot_dn;
    t_color               dot_color;
    t_color               in_color;
    logic                 setup_ready;

    assign in_color = '{red: i_red_in, green: i_green_in, blue: i_blue_in};
    assign o_stall  = !dot_ready;

    ppp_dot u_dot (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (dot_ready),
        .i_ready_dn (setup_ready),
        .i_x        (i_point_x),
        .i_y        (i_point_y),
        .i_color    (in_color),
        .i_h00      (r_row0_ab[63:32]),
        .i_h01      (r_row0_ab[31:0]),
        .i_h02      (r_h02_h10[63:32]),
        .i_h10      (r_h02_h10[31:0]),
        .i_h11      (r_h11_h12[63:32]),
        .i_h12      (r_h11_h12[31:0]),
        .i_h20      (r_h20_h21[63:32]),
        .i_h21      (r_h20_h21[31:0]),
        .i_h22      (r_h22),
        .o_valid    (dot_valid),
        .o_nx       (dot_nx),
        .o_ny       (dot_ny),
        .o_dn       (dot_dn),
        .o_color    (dot_color)
    );

    // Division chain storage: index 0 is the setup register
    logic  cv     [0:QBITS];
    t_lane lane_x [0:QBITS];
    t_lane lane_y [0:QBITS];
    t_side side   [0:QBITS];
    logic  crdy   [0:QBITS-1];
    logic  out_ready;

    // Setup: magnitudes, signs, overflow test, initial remainder
    logic [DW-1:0] mag_nx;
    logic [DW-1:0] mag_ny;
    logic [DW-1:0] mag_dn;
    t_side         n_side;
    t_lane         n_lx;
    t_lane         n_ly;

    always_comb begin
        mag_nx = dot_nx[DW-1] ? DW'(-dot_nx) : DW'(dot_nx);
        mag_ny = dot_ny[DW-1] ? DW'(-dot_ny) : DW'(dot_ny);
        mag_dn = dot_dn[DW-1] ? DW'(-dot_dn) : DW'(dot_dn);
        n_side.dmag  = mag_dn;
        n_side.nxneg = dot_nx[DW-1];
        n_side.nyneg = dot_ny[DW-1];
        n_side.negx  = dot_nx[DW-1] ^ dot_dn[DW-1];
        n_side.negy  = dot_ny[DW-1] ^ dot_dn[DW-1];
        n_side.ovfx  = {16'd0, mag_nx} >= {mag_dn, 16'd0};
        n_side.ovfy  = {16'd0, mag_ny} >= {mag_dn, 16'd0};
        n_side.degen = (dot_dn == '0);
        n_side.color = dot_color;
        n_lx.rem = {16'd0, mag_nx[DW-1:16]};
        n_lx.low = {mag_nx[15:0], 16'd0};
        n_lx.quo = '0;
        n_ly.rem = {16'd0, mag_ny[DW-1:16]};
        n_ly.low = {mag_ny[15:0], 16'd0};
        n_ly.quo = '0;
    end

    assign setup_ready = !cv[0] || crdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            cv[0] <= 1'b0;
        end else if (setup_ready) begin
            cv[0] <= dot_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (setup_ready) begin
            lane_x[0] <= n_lx;
            lane_y[0] <= n_ly;
            side[0]   <= n_side;
        end
    end

    // Chain of division cells
    for (genvar k = 0; k < QBITS; k++) begin : g_cell
        logic rdy_dn;
        if (k == QBITS - 1) begin : g_last
            assign rdy_dn = out_ready;
        end else begin : g_mid
            assign rdy_dn = crdy[k+1];
        end
        ppp_div_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_valid    (cv[k]),
            .o_ready    (crdy[k]),
            .i_ready_dn (rdy_dn),
            .i_lane_x   (lane_x[k]),
            .i_lane_y   (lane_y[k]),
            .i_side     (side[k]),
            .o_valid    (cv[k+1]),
            .o_lane_x   (lane_x[k+1]),
            .o_lane_y   (lane_y[k+1]),
            .o_side     (side[k+1])
        );
    end

    // Output stage: sign and saturate, round to pixel, inside test
    t_side              fs;
    logic [31:0]        qx;
    logic [31:0]        qy;
    logic signed [31:0] n_px;
    logic signed [31:0] n_py;
    logic signed [15:0] n_col;
    logic signed [15:0] n_row;
    logic               n_inside;

    function automatic logic signed [31:0] sat_q(input logic [31:0] q, input logic ovf,
                                                 input logic neg);
        logic signed [31:0] r;
        if (neg) begin
            r = (ovf || (q[31] && (q[30:0] != '0))) ? 32'sh8000_0000 : -$signed(q);
        end else begin
            r = (ovf || q[31]) ? 32'sh7FFF_FFFF : $signed(q);
        end
        return r;
    endfunction

    function automatic logic signed [15:0] round_pix(input logic signed [31:0] p);
        logic               inc;
        logic signed [16:0] s;
        inc = (p[15:0] > 16'h8000) || ((p[15:0] == 16'h8000) && p[16]);
        s   = $signed({p[31], p[31:16]}) + $signed({16'd0, inc});
        return (s > 17'sd32767) ? 16'sh7FFF : s[15:0];
    endfunction

    always_comb begin
        fs = side[QBITS];
        qx = lane_x[QBITS].quo;
        qy = lane_y[QBITS].quo;
        if (fs.degen) begin
            n_px = fs.nxneg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            n_py = fs.nyneg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            n_px = sat_q(qx, fs.ovfx, fs.negx);
            n_py = sat_q(qy, fs.ovfy, fs.negy);
        end
        n_col    = round_pix(n_px);
        n_row    = round_pix(n_py);
        n_inside = !fs.degen && (n_col > 16'sd0) && (n_row > 16'sd0)
                   && (n_col[14:0] < {2'd0, r_cols}) && (n_row[14:0] < {2'd0, r_rows});
    end

    assign out_ready = !o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (out_ready) begin
            o_valid <= cv[QBITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready) begin
            o_proj_x     <= n_px;
            o_proj_y     <= n_py;
            o_pixel_col  <= n_col;
            o_pixel_row  <= n_row;
            o_inside_res <= n_inside;
            o_degenerate <= fs.degen;
            o_red_out    <= fs.color.red;
            o_green_out  <= fs.color.green;
            o_blue_out   <= fs.color.blue;
        end
    end

endmodule

### hdl/ppp_chk.sv
// Port-level checker for the perspective point projection block, with its bind.
module ppp_chk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic signed [31:0] o_proj_x,
    input  logic signed [15:0] o_pixel_col,
    input  logic               o_inside_res,
    input  logic               o_degenerate
);

    // Hold a stalled word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_proj_x))
        else $error("stalled output word dropped or changed");

    // Degenerate word is never inside
    a_degen_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> !o_inside_res)
        else $error("degenerate word flagged inside");

    // Degenerate word saturates its coordinate
    a_degen_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> (o_proj_x == 32'sh7FFF_FFFF || o_proj_x == 32'sh8000_0000))
        else $error("degenerate word not saturated");

    // Inside implies a positive column
    a_inside_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_inside_res |-> o_pixel_col > 16'sd0)
        else $error("inside word with non-positive column");

endmodule

bind perspective_point_projection ppp_chk u_ppp_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_proj_x     (o_proj_x),
    .o_pixel_col  (o_pixel_col),
    .o_inside_res (o_inside_res),
    .o_degenerate (o_degenerate)
);
